// ===== src/pdr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pdr_pkg;

	localparam int DEF_CORDIC_STEPS = 16;
	localparam int CNT_W = 5;
	localparam int VW = 37;
	localparam int QW = 36;
	localparam int MW = 33;
	localparam int PW = 2 * MW;
	localparam int ACC_SHIFT = 12;
	localparam int QUAT_OPS = 8;
	localparam int INTEG_OPS = 6;
	localparam logic signed [MW-1:0] INV_GAIN = 33'sd652032874;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
		logic [15:0] time_step;
	} sample_t;

	typedef struct packed {
		logic signed [47:0] position_x;
		logic signed [47:0] position_y;
		logic signed [31:0] velocity_x;
		logic signed [31:0] velocity_y;
		logic signed [15:0] heading;
		logic saturated;
	} result_t;

	typedef enum logic [3:0] {
		OP_XX, OP_YY, OP_ZZ, OP_WW, OP_XY, OP_WZ, OP_XZ, OP_WY,
		OP_KX, OP_KY, OP_DX, OP_DY, OP_VX, OP_VY
	} mul_op_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_QUAT, ST_PREP, ST_VEC, ST_RPREP, ST_ROT, ST_INTEG, ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic mul_go;
		mul_op_t mul_op;
		logic vec_prep;
		logic vec_step;
		logic rot_prep;
		logic rot_step;
		logic [CNT_W-1:0] step;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic do_vec;
	} dp_stat_t;

	// arctan(2^-i) as a 32-bit binary angle
	function automatic logic [31:0] atan_entry(input logic [CNT_W-1:0] idx);
		logic [31:0] r;
		case (idx)
			5'd0: r = 32'd536870912;
			5'd1: r = 32'd316933406;
			5'd2: r = 32'd167458907;
			5'd3: r = 32'd85004756;
			5'd4: r = 32'd42667331;
			5'd5: r = 32'd21354465;
			5'd6: r = 32'd10680350;
			5'd7: r = 32'd5340245;
			5'd8: r = 32'd2670163;
			5'd9: r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41721;
			5'd15: r = 32'd20860;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2607;
			5'd19: r = 32'd1303;
			5'd20: r = 32'd651;
			5'd21: r = 32'd325;
			5'd22: r = 32'd162;
			5'd23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/pdr_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pdr_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/pdr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pdr_ctrl #(
	parameter int CORDIC_STEPS = pdr_pkg::DEF_CORDIC_STEPS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	input wire pdr_pkg::dp_stat_t stat,
	output pdr_pkg::dp_cmd_t cmd
);

	localparam logic [pdr_pkg::CNT_W-1:0] LAST_STEP = pdr_pkg::CNT_W'(CORDIC_STEPS - 1);

	pdr_pkg::state_t state_q, state_d;
	logic [pdr_pkg::CNT_W-1:0] cnt_q;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			pdr_pkg::ST_IDLE: if (in_valid) state_d = pdr_pkg::ST_QUAT;
			pdr_pkg::ST_QUAT: if (cnt_q == pdr_pkg::CNT_W'(pdr_pkg::QUAT_OPS))
				state_d = pdr_pkg::ST_PREP;
			pdr_pkg::ST_PREP: state_d = stat.do_vec ? pdr_pkg::ST_VEC : pdr_pkg::ST_RPREP;
			pdr_pkg::ST_VEC: if (cnt_q == LAST_STEP) state_d = pdr_pkg::ST_RPREP;
			pdr_pkg::ST_RPREP: state_d = pdr_pkg::ST_ROT;
			pdr_pkg::ST_ROT: if (cnt_q == LAST_STEP) state_d = pdr_pkg::ST_INTEG;
			pdr_pkg::ST_INTEG: if (cnt_q == pdr_pkg::CNT_W'(pdr_pkg::INTEG_OPS))
				state_d = pdr_pkg::ST_DONE;
			pdr_pkg::ST_DONE: if (out_free) state_d = pdr_pkg::ST_IDLE;
			default: state_d = pdr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.mul_op = pdr_pkg::OP_XX;
		cmd.step = cnt_q;
		case (state_q)
			pdr_pkg::ST_IDLE: cmd.load = in_valid;
			pdr_pkg::ST_QUAT: begin
				cmd.mul_go = cnt_q < pdr_pkg::CNT_W'(pdr_pkg::QUAT_OPS);
				case (cnt_q)
					5'd0: cmd.mul_op = pdr_pkg::OP_XX;
					5'd1: cmd.mul_op = pdr_pkg::OP_YY;
					5'd2: cmd.mul_op = pdr_pkg::OP_ZZ;
					5'd3: cmd.mul_op = pdr_pkg::OP_WW;
					5'd4: cmd.mul_op = pdr_pkg::OP_XY;
					5'd5: cmd.mul_op = pdr_pkg::OP_WZ;
					5'd6: cmd.mul_op = pdr_pkg::OP_XZ;
					default: cmd.mul_op = pdr_pkg::OP_WY;
				endcase
			end
			pdr_pkg::ST_PREP: cmd.vec_prep = 1'b1;
			pdr_pkg::ST_VEC: cmd.vec_step = 1'b1;
			pdr_pkg::ST_RPREP: cmd.rot_prep = 1'b1;
			pdr_pkg::ST_ROT: cmd.rot_step = 1'b1;
			pdr_pkg::ST_INTEG: begin
				// each product is registered and used in the next cycle, so velocity is fresh for position
				cmd.mul_go = cnt_q < pdr_pkg::CNT_W'(pdr_pkg::INTEG_OPS);
				case (cnt_q)
					5'd0: cmd.mul_op = pdr_pkg::OP_KX;
					5'd1: cmd.mul_op = pdr_pkg::OP_KY;
					5'd2: cmd.mul_op = pdr_pkg::OP_DX;
					5'd3: cmd.mul_op = pdr_pkg::OP_DY;
					5'd4: cmd.mul_op = pdr_pkg::OP_VX;
					default: cmd.mul_op = pdr_pkg::OP_VY;
				endcase
			end
			pdr_pkg::ST_DONE: cmd.out_load = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdr_pkg::ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) cnt_q <= '0;
			else cnt_q <= cnt_q + 1'b1;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready = (state_q == pdr_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== src/pdr_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pdr_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire pdr_pkg::sample_t sample_d,
	input wire pdr_pkg::dp_cmd_t cmd,
	output pdr_pkg::dp_stat_t stat,
	output pdr_pkg::result_t result_d
);

	localparam int VW = pdr_pkg::VW;
	localparam int QW = pdr_pkg::QW;
	localparam int MW = pdr_pkg::MW;
	localparam int PW = pdr_pkg::PW;
	localparam logic signed [PW-1:0] HALF30 = PW'(64'sd1 <<< 29);
	localparam logic signed [PW-1:0] HALF26 = PW'(64'sd1 <<< 25);
	localparam logic signed [PW-1:0] HALF20 = PW'(64'sd1 <<< 19);
	localparam logic signed [31:0] QTR_POS = 32'sh4000_0000;
	localparam logic signed [31:0] QTR_NEG = -32'sh4000_0000;

	pdr_pkg::sample_t smp_q;
	logic signed [QW-1:0] acc_d_q, acc_syz_q, acc_xy_q, acc_g_q;
	logic vec_ran_q;
	logic signed [VW-1:0] cx_q, cy_q;
	logic [31:0] cz_q, ang_q;
	logic signed [PW-1:0] prod_s1;
	pdr_pkg::mul_op_t op_s1;
	logic mvld_s1;
	logic signed [MW-1:0] wx_q, wy_q;
	logic signed [31:0] vx_q, vy_q;
	logic signed [47:0] px_q, py_q;
	logic sat_q;
	pdr_pkg::result_t res_q;

	logic signed [VW-1:0] g2, abs_g, d_ext, xv, yv;
	logic signed [VW-1:0] xs, ys, ax_ext, ay_ext;
	logic ccw;
	logic [31:0] atan_v, rot_a;
	logic rot_big;
	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] r30, r26, r20;
	logic signed [33:0] vsum;
	logic signed [31:0] vsat;
	logic vovf;
	logic signed [49:0] psum;
	logic signed [47:0] psat;
	logic povf;
	logic is_x;

	// quaternion terms to vectoring inputs
	assign g2 = VW'(acc_g_q) <<< 1;
	assign abs_g = g2[VW-1] ? -g2 : g2;
	assign d_ext = VW'(acc_d_q);
	assign xv = d_ext - (VW'(acc_syz_q) <<< 1);
	assign yv = VW'(acc_xy_q) <<< 1;
	assign stat.do_vec = abs_g < d_ext;

	// shared cordic micro-rotation
	assign xs = cx_q >>> cmd.step;
	assign ys = cy_q >>> cmd.step;
	assign atan_v = pdr_pkg::atan_entry(cmd.step);
	assign ccw = cmd.rot_step ? !cz_q[31] : cy_q[VW-1];

	assign rot_a = vec_ran_q ? cz_q : 32'd0;
	assign rot_big = ($signed(rot_a) > QTR_POS) || ($signed(rot_a) < QTR_NEG);
	assign ax_ext = VW'(smp_q.accel_x) <<< pdr_pkg::ACC_SHIFT;
	assign ay_ext = VW'(smp_q.accel_y) <<< pdr_pkg::ACC_SHIFT;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_op)
			pdr_pkg::OP_XX: begin mul_a = MW'(smp_q.quat_x); mul_b = MW'(smp_q.quat_x); end
			pdr_pkg::OP_YY: begin mul_a = MW'(smp_q.quat_y); mul_b = MW'(smp_q.quat_y); end
			pdr_pkg::OP_ZZ: begin mul_a = MW'(smp_q.quat_z); mul_b = MW'(smp_q.quat_z); end
			pdr_pkg::OP_WW: begin mul_a = MW'(smp_q.quat_w); mul_b = MW'(smp_q.quat_w); end
			pdr_pkg::OP_XY: begin mul_a = MW'(smp_q.quat_x); mul_b = MW'(smp_q.quat_y); end
			pdr_pkg::OP_WZ: begin mul_a = MW'(smp_q.quat_w); mul_b = MW'(smp_q.quat_z); end
			pdr_pkg::OP_XZ: begin mul_a = MW'(smp_q.quat_x); mul_b = MW'(smp_q.quat_z); end
			pdr_pkg::OP_WY: begin mul_a = MW'(smp_q.quat_w); mul_b = MW'(smp_q.quat_y); end
			pdr_pkg::OP_KX: begin mul_a = cx_q[MW-1:0]; mul_b = pdr_pkg::INV_GAIN; end
			pdr_pkg::OP_KY: begin mul_a = cy_q[MW-1:0]; mul_b = pdr_pkg::INV_GAIN; end
			pdr_pkg::OP_DX: begin mul_a = wx_q; mul_b = $signed(MW'(smp_q.time_step)); end
			pdr_pkg::OP_DY: begin mul_a = wy_q; mul_b = $signed(MW'(smp_q.time_step)); end
			pdr_pkg::OP_VX: begin mul_a = MW'(vx_q); mul_b = $signed(MW'(smp_q.time_step)); end
			pdr_pkg::OP_VY: begin mul_a = MW'(vy_q); mul_b = $signed(MW'(smp_q.time_step)); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// rounding, then saturating update of the selected axis
	assign r30 = (prod_s1 + HALF30) >>> 30;
	assign r26 = (prod_s1 + HALF26) >>> 26;
	assign r20 = (prod_s1 + HALF20) >>> 20;
	assign is_x = (op_s1 == pdr_pkg::OP_DX) || (op_s1 == pdr_pkg::OP_VX);

	assign vsum = 34'(is_x ? vx_q : vy_q) + r26[33:0];
	assign vovf = !((vsum[33:31] == 3'b000) || (vsum[33:31] == 3'b111));
	assign vsat = vovf ? (vsum[33] ? 32'sh8000_0000 : 32'sh7fff_ffff) : vsum[31:0];

	assign psum = 50'(is_x ? px_q : py_q) + r20[49:0];
	assign povf = !((psum[49:47] == 3'b000) || (psum[49:47] == 3'b111));
	assign psat = povf ? (psum[49] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}}) : psum[47:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvld_s1 <= 1'b0;
			vx_q <= '0;
			vy_q <= '0;
			px_q <= '0;
			py_q <= '0;
		end else begin
			mvld_s1 <= cmd.mul_go;
			if (mvld_s1) begin
				case (op_s1)
					pdr_pkg::OP_DX: vx_q <= vsat;
					pdr_pkg::OP_DY: vy_q <= vsat;
					pdr_pkg::OP_VX: px_q <= psat;
					pdr_pkg::OP_VY: py_q <= psat;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(mul_a) * PW'(mul_b);
		op_s1 <= cmd.mul_op;
		if (cmd.load) begin
			smp_q <= sample_d;
			acc_d_q <= '0;
			acc_syz_q <= '0;
			acc_xy_q <= '0;
			acc_g_q <= '0;
			sat_q <= 1'b0;
		end else if (mvld_s1) begin
			case (op_s1)
				pdr_pkg::OP_XX, pdr_pkg::OP_WW: acc_d_q <= acc_d_q + prod_s1[QW-1:0];
				pdr_pkg::OP_YY, pdr_pkg::OP_ZZ: begin
					acc_d_q <= acc_d_q + prod_s1[QW-1:0];
					acc_syz_q <= acc_syz_q + prod_s1[QW-1:0];
				end
				pdr_pkg::OP_XY, pdr_pkg::OP_WZ: acc_xy_q <= acc_xy_q + prod_s1[QW-1:0];
				pdr_pkg::OP_XZ: acc_g_q <= acc_g_q + prod_s1[QW-1:0];
				pdr_pkg::OP_WY: acc_g_q <= acc_g_q - prod_s1[QW-1:0];
				pdr_pkg::OP_KX: wx_q <= r30[MW-1:0];
				pdr_pkg::OP_KY: wy_q <= r30[MW-1:0];
				pdr_pkg::OP_DX, pdr_pkg::OP_DY: sat_q <= sat_q | vovf;
				pdr_pkg::OP_VX, pdr_pkg::OP_VY: sat_q <= sat_q | povf;
				default: ;
			endcase
		end

		if (cmd.vec_prep) begin
			vec_ran_q <= stat.do_vec;
			// left half plane: turn by pi before the micro-rotations
			if (xv[VW-1]) begin
				cx_q <= -xv;
				cy_q <= -yv;
				cz_q <= 32'h8000_0000;
			end else begin
				cx_q <= xv;
				cy_q <= yv;
				cz_q <= 32'd0;
			end
		end else if (cmd.rot_prep) begin
			ang_q <= rot_a;
			if (rot_big) begin
				cx_q <= -ax_ext;
				cy_q <= -ay_ext;
				cz_q <= {~rot_a[31], rot_a[30:0]};
			end else begin
				cx_q <= ax_ext;
				cy_q <= ay_ext;
				cz_q <= rot_a;
			end
		end else if (cmd.vec_step || cmd.rot_step) begin
			if (ccw) begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - atan_v;
			end else begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + atan_v;
			end
		end

		if (cmd.out_load) begin
			res_q.position_x <= px_q;
			res_q.position_y <= py_q;
			res_q.velocity_x <= vx_q;
			res_q.velocity_y <= vy_q;
			res_q.heading <= 16'((ang_q + 32'h0000_8000) >> 16);
			res_q.saturated <= sat_q;
		end
	end

	assign result_d = res_q;

endmodule

`default_nettype wire

// ===== src/imu_planar_dead_reckoning.sv =====
// a sample transaction starts the sequence that ends in a valid result; vectoring is skipped and
// the heading forced to zero when it cannot be found (pitch +-90 degrees, zero quaternion)
// a new sample is taken only in the idle state, once the last one is through the shared cordic
// and multiplier; the sequence waits longer while a result is stalled
// a finished result waits in an output register while the next sample is taken
// reset: asynchronous active-low, clears velocity, position and all handshake state
`timescale 1ns / 1ps
`default_nettype none

module imu_planar_dead_reckoning #(
	parameter int CORDIC_STEPS = pdr_pkg::DEF_CORDIC_STEPS
) (
	input wire logic clk,
	input wire logic arst_n,
	pdr_stream_if.sink sample,
	pdr_stream_if.source pose
);

	// command and status between sequencer and datapath
	pdr_pkg::dp_cmd_t cmd;
	pdr_pkg::dp_stat_t stat;
	pdr_pkg::result_t result_d;

	// sequencer: quaternion products, heading vectoring, rotation, then integration
	pdr_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(sample.valid),
		.in_ready(sample.ready),
		.out_valid(pose.valid),
		.out_ready(pose.ready),
		.stat(stat),
		.cmd(cmd)
	);

	// datapath: one shared multiplier, one shared cordic stage, the accumulators
	pdr_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.sample_d(sample.data),
		.cmd(cmd),
		.stat(stat),
		.result_d(result_d)
	);

	// result register drives the output transaction directly
	assign pose.data = result_d;

endmodule

`default_nettype wire

// ===== src/pdr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pdr_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire pdr_pkg::result_t out_data
);

	// one sample at a time: no second transaction straight after one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample taken in the cycle after a sample transaction");

	// a result needs the whole sequence, so out_valid does not rise in the cycle after a sample
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared one cycle after a sample");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transaction");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result changed while stalled");

endmodule

bind imu_planar_dead_reckoning pdr_checker u_pdr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(sample.valid),
	.in_ready(sample.ready),
	.out_valid(pose.valid),
	.out_ready(pose.ready),
	.out_data(pose.data)
);

`default_nettype wire
